### hw/rtl/note_waveform_oscillator_core_macros.svh
// Assertion macros used by the oscillator's checker file.
`ifndef NOTE_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`define NOTE_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH

// The antecedent in one cycle implies the consequent in the next one.
`define NWO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition holds at every clock edge outside reset.
`define NWO_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Reset low implies the consequent in the next cycle.
`define NWO_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

### hw/rtl/nwo_pkg.sv
// Shared types, constants and tables of the note waveform oscillator.
package nwo_pkg;

  // Field and register widths.
  localparam int PHASE_BITS     = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int KEY_BITS       = 7;
  localparam int AMP_BITS       = 15;
  localparam int WAVE_BITS      = 2;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE = 1'b1;

  // Waveform codes.
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 2'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 2'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 2'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 2'd3;

  // Register reset values.
  localparam logic [WAVE_BITS-1:0] WAVE_RESET = WAVE_SINE;
  localparam logic [AMP_BITS-1:0]  AMP_RESET  = 15'd3200;

  // Key split: octave = (key * 171) >> 11 equals key / 12 for 7-bit keys.
  localparam int OCT_BITS        = 4;
  localparam int SEMI_BITS       = 4;
  localparam int DIV12_MUL       = 171;
  localparam int DIV12_SHIFT     = 11;
  localparam int DIV12_PROD_BITS = KEY_BITS + 8;
  localparam logic [OCT_BITS-1:0] OCT_TOP = 4'd10;

  // Phase step table at the top octave.
  localparam int STEP_BITS = 33;

  // Q30 fixed point: one is 2^30, values span 0..2^30 inclusive.
  localparam int Q30_BITS = 31;
  localparam logic [Q30_BITS-1:0] Q30_ONE = 31'h4000_0000;

  // Sine table: 1024 entries by phase, folded to a quarter wave of 257.
  localparam int SINE_IDX_BITS = 10;
  localparam int QROM_AW       = SINE_IDX_BITS - 1;
  localparam int QROM_DEPTH    = (1 << (SINE_IDX_BITS - 2)) + 1;
  localparam int QUARTER_SH    = 30 - (SINE_IDX_BITS - 2);

  // Queue between front and back.
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_CNT_BITS = 2;

  // One queued item: the phase the sample is taken at, and the rest flag.
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic                  rest;
  } nwo_item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [WAVE_BITS-1:0] waveform;
    logic [AMP_BITS-1:0]  amplitude;
  } nwo_cfg_t;

  // Phase increment for each semitone at octave ten.
  function automatic logic [STEP_BITS-1:0] step_at(input logic [SEMI_BITS-1:0] semi);
    logic [STEP_BITS-1:0] s;
    unique case (semi)
      4'd0:    s = 33'd2588618730;
      4'd1:    s = 33'd2742546010;
      4'd2:    s = 33'd2905626283;
      4'd3:    s = 33'd3078403812;
      4'd4:    s = 33'd3261455229;
      4'd5:    s = 33'd3455391449;
      4'd6:    s = 33'd3660859716;
      4'd7:    s = 33'd3878545763;
      4'd8:    s = 33'd4109176096;
      4'd9:    s = 33'd4353520422;
      4'd10:   s = 33'd4612394218;
      4'd11:   s = 33'd4886661450;
      default: s = '0;
    endcase
    return s;
  endfunction

  // sin(u * pi/2) in Q30 for quarter-wave entry j, by an odd Horner polynomial.
  // Evaluated only at elaboration to build the constant table.
  function automatic logic [Q30_BITS-1:0] quarter_sine(input int j);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned t;
    u  = longint'(j) << QUARTER_SH;
    u2 = (u * u) >> 30;
    t  = 64'd61;
    t  = 64'd3864      - ((t * u2) >> 30);
    t  = 64'd172273    - ((t * u2) >> 30);
    t  = 64'd5026995   - ((t * u2) >> 30);
    t  = 64'd85569306  - ((t * u2) >> 30);
    t  = 64'd693598668 - ((t * u2) >> 30);
    t  = 64'd1686629713 - ((t * u2) >> 30);
    t  = (t * u) >> 30;
    if (t > 64'(Q30_ONE)) begin
      t = 64'(Q30_ONE);
    end
    return t[Q30_BITS-1:0];
  endfunction

endpackage

### hw/rtl/note_waveform_oscillator_core.sv
// Top level of the note waveform oscillator: configuration and front-to-back plumbing.
//
// Usage: each input item (key number, rest, note start) is one sample tick and
// produces exactly one signed 16-bit item on the out_ channel, in order.
// A note start clears the 32-bit phase before the sample is taken; the phase
// then advances by the key's increment, also on rests, which give zero.
// Configuration: cfg_we writes cfg_wdata into the register cfg_index selects
// (0 waveform, 1 amplitude) in the same cycle; write only while idle.
// Path: an accepted item is written into the queue; the registered table read
// happens as the item leaves the queue, then the multiply and the sign each
// have their own register before the sample is valid on out_.
// Throughput: one item per cycle while out_ready is high; the phase add and
// the sine table read are registered.
// Stall: when out_ready is low the output register holds its sample, the back
// pipeline fills and then the two-entry queue; in_ready drops once it is full.
// Reset (rst_n low, synchronous) empties the queue and pipeline, clears the
// phase, and sets waveform to sine and amplitude to 3200. No fill pass.
module note_waveform_oscillator_core (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [nwo_pkg::KEY_BITS-1:0]              in_key_number,
  input  logic                                      in_rest,
  input  logic                                      in_note_start,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [nwo_pkg::SAMPLE_BITS-1:0]    out_sample,
  input  logic                                      cfg_we,
  input  logic [nwo_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [nwo_pkg::CFG_DATA_BITS-1:0]         cfg_wdata
);

  nwo_pkg::nwo_cfg_t  cfg_r;
  nwo_pkg::nwo_item_t push_item;
  nwo_pkg::nwo_item_t pop_item;
  logic               push_valid;
  logic               push_ready;
  logic               pop_valid;
  logic               pop_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waveform  <= nwo_pkg::WAVE_RESET;
      cfg_r.amplitude <= nwo_pkg::AMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nwo_pkg::REG_WAVEFORM:  cfg_r.waveform  <= cfg_wdata[nwo_pkg::WAVE_BITS-1:0];
        nwo_pkg::REG_AMPLITUDE: cfg_r.amplitude <= cfg_wdata[nwo_pkg::AMP_BITS-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  nwo_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_number (in_key_number),
    .in_rest       (in_rest),
    .in_note_start (in_note_start),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  nwo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  nwo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

endmodule

### hw/rtl/nwo_front.sv
// Front end: accepts items, advances the phase and queues the sample phase.
module nwo_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [nwo_pkg::KEY_BITS-1:0]        in_key_number,
  input  logic                                in_rest,
  input  logic                                in_note_start,
  output logic                                push_valid,
  input  logic                                push_ready,
  output nwo_pkg::nwo_item_t                  push_item
);

  logic [nwo_pkg::PHASE_BITS-1:0]      phase_r;
  logic [nwo_pkg::PHASE_BITS-1:0]      phase_cur;
  logic [nwo_pkg::PHASE_BITS-1:0]      phase_inc;
  logic [nwo_pkg::DIV12_PROD_BITS-1:0] div_prod;
  logic [nwo_pkg::OCT_BITS-1:0]        oct;
  logic [nwo_pkg::KEY_BITS-1:0]        oct_x12;
  logic [nwo_pkg::KEY_BITS-1:0]        semi_full;
  logic [nwo_pkg::SEMI_BITS-1:0]       semi;
  logic [nwo_pkg::OCT_BITS-1:0]        shift_amt;
  logic [nwo_pkg::STEP_BITS-1:0]       step;
  logic                                accept;

  // Split the key into octave and semitone by a reciprocal multiply.
  always_comb begin
    div_prod  = nwo_pkg::DIV12_PROD_BITS'(in_key_number) *
                nwo_pkg::DIV12_PROD_BITS'(nwo_pkg::DIV12_MUL);
    oct       = div_prod[nwo_pkg::DIV12_SHIFT +: nwo_pkg::OCT_BITS];
    oct_x12   = {oct, 3'b000} + {1'b0, oct, 2'b00};
    semi_full = in_key_number - oct_x12;
    semi      = semi_full[nwo_pkg::SEMI_BITS-1:0];
  end

  // The increment is the top-octave step shifted down by the octave distance.
  always_comb begin
    shift_amt = nwo_pkg::OCT_TOP - oct;
    step      = nwo_pkg::step_at(semi);
    phase_inc = nwo_pkg::PHASE_BITS'(step >> shift_amt);
  end

  // A note start clears the phase before this item's sample is taken.
  assign phase_cur = in_note_start ? '0 : phase_r;

  assign in_ready          = push_ready;
  assign push_valid        = in_valid;
  assign accept            = in_valid && push_ready;
  assign push_item.phase   = phase_cur;
  assign push_item.rest    = in_rest;

  // Phase accumulator, wrapping modulo two to the phase width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (accept) begin
      phase_r <= phase_cur + phase_inc;
    end
  end

endmodule

### hw/rtl/nwo_queue.sv
// Two-entry item queue between the front and back ends.
module nwo_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  nwo_pkg::nwo_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output nwo_pkg::nwo_item_t pop_item
);

  nwo_pkg::nwo_item_t                  mem_r [nwo_pkg::QUEUE_DEPTH];
  logic [nwo_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_r;
  logic [nwo_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_r;
  logic [nwo_pkg::QUEUE_CNT_BITS-1:0]  count_r;
  logic                                push;
  logic                                pop;

  assign push_ready = (count_r != nwo_pkg::QUEUE_CNT_BITS'(nwo_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_item   = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/nwo_sine_rom.sv
// Quarter-wave sine table with a registered read port.
module nwo_sine_rom (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [nwo_pkg::QROM_AW-1:0]   rd_addr,
  output logic [nwo_pkg::Q30_BITS-1:0]  rd_data
);

  logic [nwo_pkg::Q30_BITS-1:0] qtab [nwo_pkg::QROM_DEPTH];
  logic [nwo_pkg::Q30_BITS-1:0] rd_data_r;

  // Table contents are fixed at elaboration.
  for (genvar j = 0; j < nwo_pkg::QROM_DEPTH; j++) begin : g_entry
    assign qtab[j] = nwo_pkg::quarter_sine(j);
  end

  // Read data is registered; it holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= qtab[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/nwo_back.sv
// Back end: shapes, scales and signs one sample per queued item.
module nwo_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nwo_pkg::nwo_cfg_t                    cfg,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  nwo_pkg::nwo_item_t                   pop_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [nwo_pkg::SAMPLE_BITS-1:0] out_sample
);

  localparam int PROD_BITS = nwo_pkg::AMP_BITS + nwo_pkg::Q30_BITS;

  // Stage one: shape selection and table read.
  logic                              s1_valid_r;
  logic                              s1_sine_r;
  logic                              s1_neg_r;
  logic [nwo_pkg::Q30_BITS-1:0]      s1_b_r;
  logic                              s1_sine_nxt;
  logic                              s1_neg_nxt;
  logic [nwo_pkg::Q30_BITS-1:0]      s1_b_nxt;
  logic [nwo_pkg::QROM_AW-1:0]       rom_addr;
  logic [nwo_pkg::Q30_BITS-1:0]      rom_data;
  logic [nwo_pkg::SINE_IDX_BITS-1:0] sine_idx;
  logic [nwo_pkg::Q30_BITS-1:0]      tri_frac;

  // Stage two: amplitude product.
  logic                              s2_valid_r;
  logic                              s2_neg_r;
  logic [nwo_pkg::AMP_BITS-1:0]      s2_mag_r;
  logic [nwo_pkg::Q30_BITS-1:0]      mul_b;
  logic [PROD_BITS-1:0]              prod;

  // Output register.
  logic                              out_valid_r;
  logic [nwo_pkg::SAMPLE_BITS-1:0]   out_sample_r;
  logic [nwo_pkg::SAMPLE_BITS-1:0]   mag_ext;

  logic en1;
  logic en2;
  logic en3;

  // Each stage moves when the one after it is empty or moving.
  assign en3       = !out_valid_r || out_ready;
  assign en2       = !s2_valid_r || en3;
  assign en1       = !s1_valid_r || en2;
  assign pop_ready = en1;

  // Fold the sine index into the quarter wave.
  always_comb begin
    sine_idx = pop_item.phase[nwo_pkg::PHASE_BITS-1 -: nwo_pkg::SINE_IDX_BITS];
    if (sine_idx[nwo_pkg::SINE_IDX_BITS-2]) begin
      rom_addr = nwo_pkg::QROM_AW'(nwo_pkg::QROM_DEPTH - 1) -
                 {1'b0, sine_idx[nwo_pkg::SINE_IDX_BITS-3:0]};
    end else begin
      rom_addr = {1'b0, sine_idx[nwo_pkg::SINE_IDX_BITS-3:0]};
    end
  end

  // Triangle magnitude at full phase resolution, in Q30.
  always_comb begin
    if (pop_item.phase[nwo_pkg::PHASE_BITS-2]) begin
      tri_frac = nwo_pkg::Q30_ONE - {1'b0, pop_item.phase[nwo_pkg::PHASE_BITS-3:0]};
    end else begin
      tri_frac = {1'b0, pop_item.phase[nwo_pkg::PHASE_BITS-3:0]};
    end
  end

  // Shape decode: every waveform becomes sign and a Q30 multiplier.
  always_comb begin
    s1_sine_nxt = 1'b0;
    s1_neg_nxt  = pop_item.phase[nwo_pkg::PHASE_BITS-1];
    s1_b_nxt    = '0;
    unique case (cfg.waveform) inside
      nwo_pkg::WAVE_SQUARE: begin
        s1_neg_nxt = (pop_item.phase == '0) || pop_item.phase[nwo_pkg::PHASE_BITS-1];
        s1_b_nxt   = nwo_pkg::Q30_ONE;
      end
      nwo_pkg::WAVE_SINE: begin
        s1_sine_nxt = 1'b1;
      end
      nwo_pkg::WAVE_TRIANGLE, nwo_pkg::WAVE_SAW: begin
        s1_b_nxt = tri_frac;
      end
      default: begin
        s1_b_nxt = '0;
      end
    endcase
    // A rest gives a zero sample.
    if (pop_item.rest) begin
      s1_sine_nxt = 1'b0;
      s1_neg_nxt  = 1'b0;
      s1_b_nxt    = '0;
    end
  end

  nwo_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (en1),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sine_r <= s1_sine_nxt;
      s1_neg_r  <= s1_neg_nxt;
      s1_b_r    <= s1_b_nxt;
    end
  end

  // Scale by the amplitude; the Q30 product never exceeds the amplitude.
  assign mul_b = s1_sine_r ? rom_data : s1_b_r;
  assign prod  = PROD_BITS'(cfg.amplitude) * PROD_BITS'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_neg_r <= s1_neg_r;
      s2_mag_r <= prod[30 +: nwo_pkg::AMP_BITS];
    end
  end

  // Apply the sign into the output register.
  assign mag_ext = {1'b0, s2_mag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_sample_r <= s2_neg_r ? (~mag_ext + 1'b1) : mag_ext;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

### hw/rtl/nwo_checker.sv
// Port-level checker for the oscillator, bound to the top level.
`include "note_waveform_oscillator_core_macros.svh"

module nwo_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [nwo_pkg::SAMPLE_BITS-1:0] out_sample
);

  // Reset empties the result path.
  `NWO_ASSERT_AFTER_RESET(a_reset_empty, !out_valid, "out_valid high right after reset")

  // A stalled item stays offered and unchanged.
  `NWO_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "stalled item dropped")
  `NWO_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(out_sample), "stalled item changed")

  // Magnitudes never exceed the amplitude, so the most negative code cannot appear.
  `NWO_ASSERT_ALWAYS(a_no_min_code, !out_valid || (out_sample != 16'h8000), "sample out of range")

endmodule

bind note_waveform_oscillator_core nwo_checker u_nwo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample)
);
